// ----- rtl/core/asmm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the array sorter with minimum and maximum.
package asmm_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_LEN_DEFAULT = 16;
    localparam int PADDR_W         = 2;
    localparam int PDATA_W         = 32;

    // Register map (byte addresses).
    localparam logic [PADDR_W-1:0] REG_DESCENDING = PADDR_W'(0);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic signed [DATA_W-1:0] largest;
        logic signed [DATA_W-1:0] smallest;
        logic                     was_sorted;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // accept the input word
        logic start;  // the accepted word closes the array
        logic emit;   // load the next sorted element into the output register
        logic clear;  // empty the array after its final element
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic final_elem;  // the next element to emit is the last of the run
    } t_status;

endpackage

// ----- rtl/core/asmm_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one word of a given payload type.
interface asmm_stream_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/asmm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: load and emit phases, output valid flag.
module asmm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    input  asmm_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output asmm_pkg::t_cmd   o_cmd
);

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == S_LOAD);
        o_cmd.take  = (r_state == S_LOAD) && i_in_valid;
        o_cmd.start = o_cmd.take && i_in_last;
        o_cmd.emit  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
        o_cmd.clear = o_cmd.emit && i_status.final_elem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (o_cmd.start) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_cmd.clear) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/asmm_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: insertion cells, running statistics, emit counter and output register.
module asmm_dpath #(
    parameter int MAX_LEN = asmm_pkg::MAX_LEN_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asmm_pkg::t_cmd      i_cmd,
    input  asmm_pkg::t_in_word  i_in_word,
    input  logic                i_descending,
    output asmm_pkg::t_status   o_status,
    output asmm_pkg::t_out_word o_out_word
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);

    logic signed [asmm_pkg::DATA_W-1:0] r_cell [MAX_LEN];
    logic signed [asmm_pkg::DATA_W-1:0] r_prev;
    logic signed [asmm_pkg::DATA_W-1:0] r_max;
    logic signed [asmm_pkg::DATA_W-1:0] r_min;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   r_emit_cnt;
    logic                               r_mono;
    logic                               r_rise;
    logic                               r_desc;
    asmm_pkg::t_out_word                r_out;

    logic signed [asmm_pkg::DATA_W-1:0] n_cell [MAX_LEN];
    logic [MAX_LEN-1:0]                 ins;
    logic                               room;
    logic                               is_final;
    logic [CNT_W-1:0]                   last_pos;
    logic [CNT_W-1:0]                   rd_pos;
    logic signed [asmm_pkg::DATA_W-1:0] v;

    assign v        = i_in_word.value;
    assign room     = (r_count < CNT_W'(MAX_LEN));
    assign last_pos = CNT_W'(r_count - 1'b1);
    assign is_final = (r_emit_cnt == last_pos);
    assign rd_pos   = r_desc ? CNT_W'(last_pos - r_emit_cnt) : r_emit_cnt;

    // Cells stay in ascending order; a cell moves up when it holds a larger value
    // than the new one or lies beyond the filled part.
    always_comb begin
        for (int i = 0; i < MAX_LEN; i++) begin
            ins[i] = (CNT_W'(i) < r_count) ? (r_cell[i] > v) : 1'b1;
        end
        for (int i = 0; i < MAX_LEN; i++) begin
            if (!ins[i]) begin
                n_cell[i] = r_cell[i];
            end else if (i == 0) begin
                n_cell[i] = v;
            end else if (!ins[i-1]) begin
                n_cell[i] = v;
            end else begin
                n_cell[i] = r_cell[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && room) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                r_cell[i] <= n_cell[i];
            end
            r_prev <= v;
            if (r_count == '0) begin
                r_max <= v;
                r_min <= v;
            end else begin
                if (v > r_max) begin
                    r_max <= v;
                end
                if (v < r_min) begin
                    r_min <= v;
                end
            end
        end
        if (i_cmd.emit) begin
            r_out.sorted_value <= r_cell[rd_pos[IDX_W-1:0]];
            r_out.end_of_run   <= is_final;
            r_out.largest      <= r_max;
            r_out.smallest     <= r_min;
            r_out.was_sorted   <= r_mono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_emit_cnt <= '0;
            r_mono     <= 1'b1;
            r_rise     <= 1'b0;
            r_desc     <= 1'b0;
        end else begin
            if (i_cmd.take && room) begin
                r_count <= CNT_W'(r_count + 1'b1);
                if (r_count == CNT_W'(1)) begin
                    r_rise <= (v > r_prev);
                    if (v == r_prev) begin
                        r_mono <= 1'b0;
                    end
                end else if (r_count != '0) begin
                    if (r_rise ? !(v > r_prev) : !(v < r_prev)) begin
                        r_mono <= 1'b0;
                    end
                end
            end
            if (i_cmd.start) begin
                r_emit_cnt <= '0;
                r_desc     <= i_descending;
            end else if (i_cmd.emit) begin
                r_emit_cnt <= CNT_W'(r_emit_cnt + 1'b1);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_mono  <= 1'b1;
                r_rise  <= 1'b0;
            end
        end
    end

    assign o_status.final_elem = is_final;
    assign o_out_word          = r_out;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("element count beyond capacity");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && room && !i_cmd.clear) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("element count did not advance on a stored word");

    a_emit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_emit_cnt < r_count))
        else $error("emit past the filled cells");

    a_cells_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_cell[0] <= r_cell[1]))
        else $error("insertion cells out of order");

endmodule

// ----- rtl/core/array_sort_min_max_core.sv -----
`timescale 1ns / 1ps
// Top level of the array sorter with minimum, maximum and monotone check.
//
// Signed 32-bit words are loaded one per clock cycle and kept in ascending order by
// a row of insertion cells, so the sort is finished by the time the word flagged
// is_last is accepted. The block then emits the array, one result word per cycle
// while the consumer is ready, ascending or in reverse as the descending register
// held when the closing word arrived; each result also carries the array maximum,
// minimum and the monotone flag. The input is held off while the array is emitted;
// the last result sits in the output register while loading of the next array
// resumes. Up to MAX_LEN elements are held; further words are dropped, though a
// dropped word with is_last still closes the array. The descending register sits at
// byte address 0 of the APB-style port; writes take effect at once and should be
// made while the block is idle.
module array_sort_min_max_core #(
    parameter int MAX_LEN = asmm_pkg::MAX_LEN_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    asmm_stream_if.sink                   i_in,
    asmm_stream_if.source                 o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [asmm_pkg::PADDR_W-1:0]  paddr,
    input  logic [asmm_pkg::PDATA_W-1:0]  pwdata,
    output logic [asmm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic                r_descending;
    asmm_pkg::t_cmd      cmd;
    asmm_pkg::t_status   status;
    asmm_pkg::t_in_word  in_word;
    asmm_pkg::t_out_word out_word;

    // Configuration register: written in the access phase of an APB write.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == asmm_pkg::REG_DESCENDING)) begin
            r_descending <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == asmm_pkg::REG_DESCENDING) begin
            prdata[0] = r_descending;
        end
    end

    assign in_word = i_in.data;

    // The controller sequences the load and emit phases.
    asmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (in_word.is_last),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the sorted cells, the statistics and the result register.
    asmm_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_word    (in_word),
        .i_descending (r_descending),
        .o_status     (status),
        .o_out_word   (out_word)
    );

    assign o_out.data = out_word;

endmodule

// ----- test/sort_result_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts and compares the sorted result words of the array sorter.
module sort_result_checker
    import asmm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_word           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_word          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_words_due
);

    logic signed [DATA_W-1:0] held_values [MAX_LEN];
    int                       held_count;
    logic                     still_monotone;
    logic                     first_rose;
    logic                     order_down;
    t_out_word                sorted_words_due [$];
    int                       fail_count = 0;

    // Adds one element to the loading array unless full; tracks whether it stays monotone.
    function automatic void take_element(logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] prev;
        if (held_count >= MAX_LEN) begin
            return;
        end
        if (held_count >= 1) begin
            prev = held_values[held_count - 1];
            if (held_count == 1) begin
                first_rose = (v > prev);
                if (!first_rose && v == prev) begin
                    still_monotone = 1'b0;
                end
            end else if (first_rose) begin
                if (!(v > prev)) begin
                    still_monotone = 1'b0;
                end
            end else if (!(v < prev)) begin
                still_monotone = 1'b0;
            end
        end
        held_values[held_count] = v;
        held_count++;
    endfunction

    // Sorts the held array and queues one expected word per element.
    function automatic void predict_sorted_run();
        logic signed [DATA_W-1:0] run [MAX_LEN];
        logic signed [DATA_W-1:0] top_val;
        logic signed [DATA_W-1:0] bottom_val;
        logic signed [DATA_W-1:0] x;
        int                       j;
        t_out_word                w;
        for (int i = 0; i < held_count; i++) begin
            run[i] = held_values[i];
        end
        top_val    = run[0];
        bottom_val = run[0];
        for (int i = 1; i < held_count; i++) begin
            if (run[i] > top_val) begin
                top_val = run[i];
            end
            if (run[i] < bottom_val) begin
                bottom_val = run[i];
            end
        end
        for (int i = 1; i < held_count; i++) begin
            x = run[i];
            j = i;
            while (j > 0 && (order_down ? (x > run[j - 1]) : (x < run[j - 1]))) begin
                run[j] = run[j - 1];
                j--;
            end
            run[j] = x;
        end
        for (int i = 0; i < held_count; i++) begin
            w.sorted_value = run[i];
            w.end_of_run   = (i == held_count - 1);
            w.largest      = top_val;
            w.smallest     = bottom_val;
            w.was_sorted   = still_monotone;
            sorted_words_due.push_back(w);
        end
        held_count     = 0;
        still_monotone = 1'b1;
        first_rose     = 1'b0;
    endfunction

    function automatic void check_field(string name, logic signed [DATA_W-1:0] want,
                                        logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held_count     = 0;
            still_monotone = 1'b1;
            first_rose     = 1'b0;
            order_down     = 1'b0;
            sorted_words_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_DESCENDING) begin
                order_down = i_pwdata[0];
            end
            if (i_in_valid && i_in_ready) begin
                take_element(i_in_data.value);
                if (i_in_data.is_last) begin
                    predict_sorted_run();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (sorted_words_due.size() == 0) begin
                    $error("sorted_value: expected none, actual %0d", i_out_data.sorted_value);
                    fail_count++;
                end else begin
                    want = sorted_words_due.pop_front();
                    check_field("sorted_value", want.sorted_value, i_out_data.sorted_value);
                    check_field("end_of_run", want.end_of_run, i_out_data.end_of_run);
                    check_field("largest", want.largest, i_out_data.largest);
                    check_field("smallest", want.smallest, i_out_data.smallest);
                    check_field("was_sorted", want.was_sorted, i_out_data.was_sorted);
                end
            end
        end
        o_words_due  <= sorted_words_due.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- test/tb_array_sort_min_max_core.sv -----
`timescale 1ns / 1ps
// Testbench top of the array sorter: stimulus, handshake pacing and the verdict.
module tb_array_sort_min_max_core;
    import asmm_pkg::*;

    localparam int MAX_LEN       = MAX_LEN_DEFAULT;
    // Cycles without any accepted word or register access before the run is abandoned.
    localparam int QUIET_LIMIT   = 4000;
    // Cycles allowed after the last expected word for the block to settle.
    localparam int SETTLE_CYCLES = 8;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] CORNER_VALUES [5] = '{INT_MIN, INT_MAX, -1, 0, 1};

    // Shapes of the random arrays.
    typedef enum int {
        PAT_SCATTER     = 0,
        PAT_RISING      = 1,
        PAT_FALLING     = 2,
        PAT_FEW_VALUES  = 3,
        PAT_OVERFLOW    = 4,
        PAT_BROKEN_RISE = 5,
        PAT_EXTREMES    = 6,
        PAT_BROKEN_FALL = 7
    } t_pattern;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int words_due;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // The array that is about to be sent, in loading order.
    logic signed [DATA_W-1:0] run_values [$];

    asmm_stream_if #(.t_word(t_in_word))  in_ch ();
    asmm_stream_if #(.t_word(t_out_word)) out_ch ();

    array_sort_min_max_core #(
        .MAX_LEN (MAX_LEN)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker sees both channels and the register port; it owns the prediction.
    sort_result_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether it will take a word.
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offers one word and returns at the falling edge after it has been accepted.
    // Valid is left high, so that back-to-back words need no second assignment in
    // the same time step; it is lowered when the sender idles or the input is drained.
    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic last);
        t_in_word w;
        w.value   = v;
        w.is_last = last;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_array();
        for (int i = 0; i < run_values.size(); i++) begin
            send_word(run_values[i], i == run_values.size() - 1);
        end
    endtask

    // Withdraws the input and waits until every expected word has arrived, then
    // lets the block settle. Register writes and the end of the run follow this.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (words_due != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup cycle, then the access cycle, which completes once pready is seen.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Fills run_values with one random array. Many arrays are monotone runs or
    // near misses, since those are what exercise the monotone flag; the rest are
    // scattered values, heavy repeats, corner values and arrays that overfill
    // the store, whose surplus words the block must drop.
    task automatic build_array();
        int                       r;
        int                       len;
        int                       brk;
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] step;
        logic signed [DATA_W-1:0] v;
        t_pattern                 kind;
        r    = $urandom_range(0, 9);
        kind = (r < 3) ? PAT_SCATTER : t_pattern'(r - 2);
        len  = $urandom_range(1, MAX_LEN);
        if (kind == PAT_OVERFLOW) begin
            len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
        end
        if (kind == PAT_BROKEN_RISE || kind == PAT_BROKEN_FALL) begin
            len = $urandom_range(2, MAX_LEN);
        end
        // Base below zero and steps small enough that no run can overflow.
        base = $urandom_range(0, 32'h3FFF_FFFF);
        base = base - 32'sh4000_0000;
        step = $urandom_range(1, 32'h0400_0000);
        run_values.delete();
        for (int i = 0; i < len; i++) begin
            case (kind)
                PAT_RISING, PAT_BROKEN_RISE: begin
                    v = base + i * step;
                end
                PAT_FALLING, PAT_BROKEN_FALL: begin
                    v = base + (len - 1 - i) * step;
                end
                PAT_FEW_VALUES: begin
                    v = $urandom_range(0, 3);
                    v = v - 1;
                end
                PAT_EXTREMES: begin
                    v = CORNER_VALUES[$urandom_range(0, 4)];
                end
                default: begin
                    v = $urandom;
                end
            endcase
            run_values.push_back(v);
        end
        // A repeated neighbour somewhere breaks an otherwise monotone run.
        if (kind == PAT_BROKEN_RISE || kind == PAT_BROKEN_FALL) begin
            brk             = $urandom_range(1, len - 1);
            run_values[brk] = run_values[brk - 1];
        end
    endtask

    // One phase of random arrays under a given register setting and pacing. With
    // hold set, the sender waits for every result of an array before the next.
    task automatic run_phase(input int idle, input int stall, input logic [PDATA_W-1:0] reg_word,
                             input int target, input bit hold);
        int sent;
        drain();
        apb_write(REG_DESCENDING, reg_word);
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < target) begin
            build_array();
            send_array();
            sent += run_values.size();
            if (hold) begin
                drain();
            end
        end
    endtask

    initial begin : stimulus
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        rst_n        <= 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed arrays in the ascending order that reset selects: single
        // elements at both extremes, the extremes as a rising and as a falling
        // pair, an equal first pair, a rise spoilt by an equal pair at the end,
        // a clean fall and a fall that turns upwards.
        run_values = '{INT_MIN};
        send_array();
        run_values = '{INT_MAX};
        send_array();
        run_values = '{INT_MIN, INT_MAX};
        send_array();
        run_values = '{INT_MAX, INT_MIN};
        send_array();
        run_values = '{-1, -1};
        send_array();
        run_values = '{-5, 0, 7, 7};
        send_array();
        run_values = '{9, 3, -2, -8};
        send_array();
        run_values = '{2, 1, 5};
        send_array();

        // Descending order, written with every bit of the data word set.
        drain();
        apb_write(REG_DESCENDING, 32'hFFFF_FFFF);
        run_values = '{INT_MAX, 0, INT_MIN};
        send_array();
        run_values = '{INT_MIN, 0, INT_MAX};
        send_array();

        // Random phases. The first write sets every bit but bit 0, so the
        // order must revert to ascending.
        run_phase(0, 0, 32'hFFFF_FFFE, 32, 1'b0);
        run_phase(76, 0, 32'h0000_0001, 32, 1'b1);
        run_phase(0, 76, 32'h0000_0000, 32, 1'b0);
        run_phase(38, 38, 32'h0000_0001, 32, 1'b0);

        drain();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Ends the run if nothing moves for too long: no word accepted on either
    // channel and no register access.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/asmm_pkg.sv
rtl/core/asmm_stream_if.sv
rtl/core/asmm_ctrl.sv
rtl/core/asmm_dpath.sv
rtl/core/array_sort_min_max_core.sv
test/sort_result_checker.sv
test/tb_array_sort_min_max_core.sv
